/* design/qes_pkg.sv */
// shared constants, types and helper functions for the quadrature encoder speed block
package qes_pkg;

    // width of the internal tick and revolution counters
    localparam int COUNT_WIDTH = 32;
    // width of the reported totals and of the speed value
    localparam int OUT_WIDTH   = 32;
    // width of timestamps and of the divisor
    localparam int TIME_WIDTH  = 32;
    localparam int WIN_WIDTH   = 16;
    localparam logic [WIN_WIDTH-1:0] WIN_RESET = 16'd100;
    // width wide enough for the counters and the reported values
    localparam int EXT_WIDTH   = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;
    // iteration counter width of the serial divider
    localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH + 1);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic signed [1:0]      dir_t;

    localparam dir_t DIR_NONE = 2'sb00;
    localparam dir_t DIR_FWD  = 2'sb01;
    localparam dir_t DIR_REV  = 2'sb11;

    // gray sequence 0-1-3-2-0 is forward, reverse order is backward
    function automatic dir_t step_dir(input logic [1:0] prev, input logic [1:0] cur);
        dir_t d;
        case ({prev, cur})
            4'b00_01: d = DIR_FWD;
            4'b01_11: d = DIR_FWD;
            4'b11_10: d = DIR_FWD;
            4'b10_00: d = DIR_FWD;
            4'b00_10: d = DIR_REV;
            4'b10_11: d = DIR_REV;
            4'b11_01: d = DIR_REV;
            4'b01_00: d = DIR_REV;
            default:  d = DIR_NONE;
        endcase
        return d;
    endfunction

    // add a direction of -1, 0 or +1 to a wrapping counter
    function automatic count_t add_dir(input count_t v, input dir_t d);
        count_t inc;
        inc = {{(COUNT_WIDTH-2){d[1]}}, d};
        return v + inc;
    endfunction

endpackage

/* design/qes_if.sv */
// handshake channel interfaces for samples, results and window configuration

interface qes_in_if;
    logic        valid;
    logic        ready;
    logic        phase_a;
    logic        phase_b;
    logic        index_z;
    logic [31:0] now_ms;

    modport source (output valid, phase_a, phase_b, index_z, now_ms, input ready);
    modport sink   (input valid, phase_a, phase_b, index_z, now_ms, output ready);
endinterface

interface qes_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tick_total;
    logic signed [31:0] revolution_total;
    logic signed [31:0] speed_value;
    logic signed [1:0]  direction_now;
    logic               speed_fresh;

    modport source (output valid, tick_total, revolution_total, speed_value,
                    direction_now, speed_fresh, input ready);
    modport sink   (input valid, tick_total, revolution_total, speed_value,
                    direction_now, speed_fresh, output ready);
endinterface

interface qes_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] window_ms;

    modport source (output valid, window_ms, input ready);
    modport sink   (input valid, window_ms, output ready);
endinterface

/* design/qes_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module qes_div
    import qes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  count_t                dividend,
    input  logic [TIME_WIDTH-1:0] divisor,
    output logic                  done,
    output count_t                quotient
);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_WIDTH-1:0] rem_reg, rem_next;
    logic [TIME_WIDTH-1:0] dsr_reg, dsr_next;
    count_t                quo_reg, quo_next;

    logic [TIME_WIDTH:0]   trial;
    logic [TIME_WIDTH:0]   diff;
    logic                  fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[COUNT_WIDTH-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(COUNT_WIDTH);
            rem_next = '0;
            dsr_next = divisor;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
            quo_next = {quo_reg[COUNT_WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/quadrature_encoder_speed.sv */
// top level: quadrature decoder with index count and windowed speed measurement
//
// channel  | role   | payload
// ---------+--------+------------------------------------------------------------
// sample   | sink   | phase_a, phase_b, index_z, now_ms
// result   | source | tick_total, revolution_total, speed_value, direction_now,
//          |        | speed_fresh
// cfg      | sink   | window_ms (always ready)
//
// an item that does not close a window goes through accept, window check and result load
// an item that closes a window also passes the divide state, where the serial divider
// produces one quotient bit per cycle and then raises its done flag
// sample.ready is high only while the sequencer is idle; a pending result does not
// block it, the result register only holds the sequencer in its load state
// reset clears all counters, the window and the speed to zero and window_ms to 100
module quadrature_encoder_speed
    import qes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    qes_in_if.sink    sample,
    qes_out_if.source result,
    qes_cfg_if.sink   cfg
);

    // one-hot sequencer
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;

    // encoder and window state
    logic [WIN_WIDTH-1:0]  win_ms_reg, win_ms_next;
    logic [1:0]            phase_reg, phase_next;
    count_t                tick_reg, tick_next;
    dir_t                  dir_reg, dir_next;
    count_t                rev_reg, rev_next;
    logic                  seen_reg, seen_next;
    count_t                wticks_reg, wticks_next;
    logic [TIME_WIDTH-1:0] wstart_reg, wstart_next;
    logic [OUT_WIDTH-1:0]  speed_reg, speed_next;

    // per item working registers
    logic [TIME_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                  fresh_reg, fresh_next;
    logic                  neg_reg, neg_next;

    // result register
    logic                  ovalid_reg, ovalid_next;
    logic                  load;

    // combinational helpers
    logic [1:0]            cur_phase;
    dir_t                  step;
    dir_t                  dir_upd;
    logic [WIN_WIDTH-1:0]  win_eff;
    logic [TIME_WIDTH-1:0] elapsed;
    count_t                delta;
    count_t                mag;
    logic                  div_start;
    logic                  div_done;
    count_t                quotient;
    logic [EXT_WIDTH-1:0]  q_ext;
    logic [EXT_WIDTH-1:0]  q_signed;
    logic [EXT_WIDTH-1:0]  tick_ext;
    logic [EXT_WIDTH-1:0]  rev_ext;
    logic                  accept;

    assign accept    = sample.valid && sample.ready;
    assign cur_phase = {sample.phase_a, sample.phase_b};
    assign step      = step_dir(phase_reg, cur_phase);
    assign dir_upd   = (step != DIR_NONE) ? step : dir_reg;
    // a zero window length behaves as one millisecond
    assign win_eff   = (win_ms_reg == '0) ? WIN_WIDTH'(1) : win_ms_reg;
    assign elapsed   = sample.now_ms - wstart_reg;

    // tick delta over the window, taken as sign and magnitude for the divider
    assign delta     = tick_reg - wticks_reg;
    assign mag       = delta[COUNT_WIDTH-1] ? (count_t'(0) - delta) : delta;
    assign div_start = (state_reg == S_CALC) && fresh_reg;

    assign q_ext     = EXT_WIDTH'(quotient);
    assign q_signed  = neg_reg ? (EXT_WIDTH'(0) - q_ext) : q_ext;
    assign tick_ext  = EXT_WIDTH'(tick_reg);
    assign rev_ext   = EXT_WIDTH'(rev_reg);

    assign load      = (state_reg == S_DONE) && (!ovalid_reg || result.ready);

    qes_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next   = state_reg;
        win_ms_next  = win_ms_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        dir_next     = dir_reg;
        rev_next     = rev_reg;
        seen_next    = seen_reg;
        wticks_next  = wticks_reg;
        wstart_next  = wstart_reg;
        speed_next   = speed_reg;
        elapsed_next = elapsed_reg;
        fresh_next   = fresh_reg;
        neg_next     = neg_reg;
        ovalid_next  = ovalid_reg;

        if (cfg.valid)
        begin
            win_ms_next = cfg.window_ms;
        end

        if (result.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // decode the step and update tick, direction and phase
                    if (step != DIR_NONE)
                    begin
                        tick_next = add_dir(tick_reg, step);
                    end
                    dir_next   = dir_upd;
                    phase_next = cur_phase;
                    // index: count once on the first low sample, re-arm when high
                    if (!sample.index_z && !seen_reg)
                    begin
                        rev_next  = add_dir(rev_reg, dir_upd);
                        seen_next = 1'b1;
                    end
                    else if (sample.index_z)
                    begin
                        seen_next = 1'b0;
                    end
                    // window check on the wrapping timestamp difference
                    elapsed_next = elapsed;
                    fresh_next   = (elapsed >= TIME_WIDTH'(win_eff));
                    if (elapsed >= TIME_WIDTH'(win_eff))
                    begin
                        wstart_next = sample.now_ms;
                    end
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                // divider starts here when the window closed
                if (fresh_reg)
                begin
                    neg_next    = delta[COUNT_WIDTH-1];
                    wticks_next = tick_reg;
                    state_next  = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    speed_next = q_signed[OUT_WIDTH-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            win_ms_reg  <= WIN_RESET;
            phase_reg   <= '0;
            tick_reg    <= '0;
            dir_reg     <= DIR_NONE;
            rev_reg     <= '0;
            seen_reg    <= 1'b0;
            wticks_reg  <= '0;
            wstart_reg  <= '0;
            speed_reg   <= '0;
            fresh_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            win_ms_reg  <= win_ms_next;
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            dir_reg     <= dir_next;
            rev_reg     <= rev_next;
            seen_reg    <= seen_next;
            wticks_reg  <= wticks_next;
            wstart_reg  <= wstart_next;
            speed_reg   <= speed_next;
            fresh_reg   <= fresh_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // per item working values and result payload, no reset needed
    logic signed [OUT_WIDTH-1:0] o_tick_reg;
    logic signed [OUT_WIDTH-1:0] o_rev_reg;
    logic signed [OUT_WIDTH-1:0] o_speed_reg;
    dir_t                        o_dir_reg;
    logic                        o_fresh_reg;

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        neg_reg     <= neg_next;
        if (load)
        begin
            o_tick_reg  <= tick_ext[OUT_WIDTH-1:0];
            o_rev_reg   <= rev_ext[OUT_WIDTH-1:0];
            o_speed_reg <= speed_reg;
            o_dir_reg   <= dir_reg;
            o_fresh_reg <= fresh_reg;
        end
    end

    assign sample.ready            = (state_reg == S_IDLE);
    assign cfg.ready               = 1'b1;
    assign result.valid            = ovalid_reg;
    assign result.tick_total       = o_tick_reg;
    assign result.revolution_total = o_rev_reg;
    assign result.speed_value      = o_speed_reg;
    assign result.direction_now    = o_dir_reg;
    assign result.speed_fresh      = o_fresh_reg;

    // an accepted item always moves the sequencer on to the window check
    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_CALC)
        else $error("accepted item did not enter window check");

    // the divider only reports completion while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    // a window that did not close never starts the divider
    a_no_div_without_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC && !fresh_reg) |=> state_reg == S_DONE)
        else $error("divider path taken without closed window");

    // the result register is only reloaded once the previous item is taken
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !load)
        else $error("result overwritten before taken");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the quadrature encoder speed block: random samples, own predictor
module tb_top
    import qes_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // generous cycle budget: roughly 700 items, plus hold-offs
    localparam int CYCLE_LIMIT = 400000;
    // cycles to let pass once the last reading is in (divider worst case plus margin)
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD = 300;

    // one encoder sample waiting to go out
    typedef struct {
        logic [1:0]  phase;
        logic        index_z;
        logic [31:0] now_ms;
        bit          drain_first;
    } sample_item_t;

    // one expected or observed reading
    typedef struct {
        logic signed [31:0] ticks;
        logic signed [31:0] revs;
        logic signed [31:0] speed;
        dir_t               dir;
        logic               fresh;
    } reading_t;

    logic clk;
    logic rst_n;

    qes_in_if  sample_ch ();
    qes_out_if result_ch ();
    qes_cfg_if cfg_ch ();

    quadrature_encoder_speed dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // pending samples and readings still owed by the block
    sample_item_t samples_pending [$];
    reading_t     readings_due [$];

    // predictor state, mirrors the block from reset
    logic [15:0]        window_len  = WIN_RESET;
    logic [1:0]         enc_phase   = 2'd0;
    logic [31:0]        tick_count  = '0;
    dir_t               heading     = DIR_NONE;
    logic [31:0]        rev_count   = '0;
    logic               index_armed = 1'b0;
    logic [31:0]        win_ticks   = '0;
    logic [31:0]        win_start   = '0;
    logic signed [31:0] speed_now   = '0;

    // stimulus generator state
    logic [1:0]  gen_phase;
    logic [31:0] gen_ms;
    bit          gen_forward = 1'b1;
    int          z_low_left  = 0;

    // handshake bookkeeping between the edge processes
    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;
    int gap_left  = 0;
    int stall_left = 0;
    int max_gap_in = 6;
    int max_stall_out = 6;
    int hold_request = 0;
    int hold_left = 0;

    int cycle_count = 0;
    int err_count = 0;
    int samples_sent = 0;
    int readings_checked = 0;
    int windows_closed = 0;
    int index_hits = 0;
    int jumps_seen = 0;
    logic [15:0] mid_len;
    logic [15:0] short_len;

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // gray order 0-1-3-2-0 is forward
    function automatic logic [1:0] gray_forward(input logic [1:0] p);
        case (p)
            2'd0: return 2'd1;
            2'd1: return 2'd3;
            2'd3: return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] gray_reverse(input logic [1:0] p);
        case (p)
            2'd0: return 2'd2;
            2'd2: return 2'd3;
            2'd3: return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    // advance the predictor by one accepted sample and form the reading it owes
    task automatic track_encoder(input logic [1:0] cur, input logic z, input logic [31:0] ms,
                                 output reading_t r);
        logic [31:0] elapsed;
        logic [31:0] delta;
        logic [31:0] mag;
        logic [31:0] quot;
        logic [15:0] span;
        logic        neg;
        // decode the step against the last phase; a two-step jump counts nothing
        if (cur == gray_forward(enc_phase))
        begin
            tick_count = tick_count + 32'd1;
            heading = DIR_FWD;
        end
        else if (cur == gray_reverse(enc_phase))
        begin
            tick_count = tick_count - 32'd1;
            heading = DIR_REV;
        end
        else if (cur != enc_phase)
        begin
            jumps_seen++;
        end
        enc_phase = cur;
        // first low index sample since reset or since the last high one bumps the revolution count
        if (!z && !index_armed)
        begin
            if (heading == DIR_FWD)
                rev_count = rev_count + 32'd1;
            else if (heading == DIR_REV)
                rev_count = rev_count - 32'd1;
            index_armed = 1'b1;
            index_hits++;
        end
        else if (z)
        begin
            index_armed = 1'b0;
        end
        // window check, a zero length behaves as one millisecond
        span = (window_len == 16'd0) ? 16'd1 : window_len;
        elapsed = ms - win_start;
        r.fresh = 1'b0;
        if (elapsed >= {16'd0, span})
        begin
            delta = tick_count - win_ticks;
            neg = delta[31];
            mag = neg ? -delta : delta;
            quot = mag / elapsed;
            speed_now = neg ? -quot : quot;
            win_ticks = tick_count;
            win_start = ms;
            r.fresh = 1'b1;
            windows_closed++;
        end
        r.ticks = tick_count;
        r.revs = rev_count;
        r.speed = speed_now;
        r.dir = heading;
    endtask

    function automatic void compare_field(input string name, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // monitor: all sampling happens at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : edge_monitor
        reading_t want;
        reading_t got;
        cycle_count++;
        in_taken = rst_n && sample_ch.valid && sample_ch.ready;
        out_taken = rst_n && result_ch.valid && result_ch.ready;
        // register write lands on the same edge in the predictor
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            window_len = cfg_ch.window_ms;
        if (in_taken)
        begin
            track_encoder({sample_ch.phase_a, sample_ch.phase_b}, sample_ch.index_z,
                          sample_ch.now_ms, want);
            readings_due.push_back(want);
            samples_sent++;
        end
        if (out_taken)
        begin
            got.ticks = result_ch.tick_total;
            got.revs = result_ch.revolution_total;
            got.speed = result_ch.speed_value;
            got.dir = result_ch.direction_now;
            got.fresh = result_ch.speed_fresh;
            if (readings_due.size() == 0)
            begin
                $error("reading with nothing outstanding: ticks %0d", got.ticks);
                err_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                compare_field("tick_total", want.ticks, got.ticks);
                compare_field("revolution_total", want.revs, got.revs);
                compare_field("speed_value", want.speed, got.speed);
                compare_field("direction_now", want.dir, got.dir);
                compare_field("speed_fresh", want.fresh, got.fresh);
                readings_checked++;
            end
        end
    end

    // long receiver hold-off, counted down in its own process
    always @(posedge clk)
    begin : long_hold_timer
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
        end
    end

    // ---------------------------------------------------------------
    // sample driver: changes inputs at the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : sample_driver
        sample_item_t nxt;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else
        begin
            // fresh gap drawn for every item that went in
            if (in_taken)
                gap_left = $urandom_range(0, max_gap_in);
            // an offered item stays put until taken
            if (!(sample_ch.valid && !in_taken))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    sample_ch.valid <= 1'b0;
                end
                else if (samples_pending.size() != 0 &&
                         !(samples_pending[0].drain_first && readings_due.size() != 0))
                begin
                    nxt = samples_pending.pop_front();
                    sample_ch.phase_a <= nxt.phase[1];
                    sample_ch.phase_b <= nxt.phase[0];
                    sample_ch.index_z <= nxt.index_z;
                    sample_ch.now_ms <= nxt.now_ms;
                    sample_ch.valid <= 1'b1;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result ready: random stalls per reading, or low during a long hold-off
    always @(negedge clk)
    begin : result_ready_driver
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_taken)
                stall_left = $urandom_range(0, max_stall_out);
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_sample(input logic [1:0] ph, input logic z, input logic [31:0] ms);
        sample_item_t it;
        it.phase = ph;
        it.index_z = z;
        it.now_ms = ms;
        it.drain_first = 1'b0;
        samples_pending.push_back(it);
        gen_phase = ph;
        gen_ms = ms;
    endtask

    // mostly clean gray motion in runs, with some invalid jumps, pauses and odd timestamps
    task automatic queue_motion(input int n, input int step_max, input int still_pct,
                                input int drain_at);
        sample_item_t it;
        int roll;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                gen_phase = gen_phase ^ 2'b11;
            else if (roll >= 15)
            begin
                if ($urandom_range(0, 19) == 0)
                    gen_forward = !gen_forward;
                gen_phase = gen_forward ? gray_forward(gen_phase) : gray_reverse(gen_phase);
            end
            // index pulses low for one to three samples now and then
            if (z_low_left == 0 && $urandom_range(0, 19) == 0)
                z_low_left = $urandom_range(1, 3);
            it.index_z = (z_low_left == 0);
            if (z_low_left != 0)
                z_low_left--;
            // time: usually moves forward, sometimes stands still, jumps or steps back
            roll = $urandom_range(0, 99);
            if (roll < 3)
                gen_ms = $urandom();
            else if (roll < 5)
                gen_ms = gen_ms - $urandom_range(1, 1000);
            else if (roll >= 5 + still_pct)
                gen_ms = gen_ms + $urandom_range(1, step_max);
            it.phase = gen_phase;
            it.now_ms = gen_ms;
            it.drain_first = (k == drain_at);
            samples_pending.push_back(it);
        end
    endtask

    // wait for the block to go quiet before touching the register
    task automatic wait_drained();
        while (samples_pending.size() != 0 || readings_due.size() != 0 || sample_ch.valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [15:0] len);
        wait_drained();
        @(negedge clk);
        cfg_ch.window_ms <= len;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.phase_a = 1'b0;
        sample_ch.phase_b = 1'b0;
        sample_ch.index_z = 1'b1;
        sample_ch.now_ms = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.window_ms = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, reset window of 100 ms
        // index low before any movement: nothing added, but it arms
        push_sample(2'd0, 1'b0, 32'd0);
        // one forward turn, index re-armed then hit on the way
        push_sample(2'd1, 1'b1, 32'd10);
        push_sample(2'd3, 1'b1, 32'd20);
        push_sample(2'd2, 1'b1, 32'd30);
        push_sample(2'd0, 1'b0, 32'd40);
        // index held low counts only once
        push_sample(2'd0, 1'b0, 32'd50);
        // exactly one window length later: window closes
        push_sample(2'd1, 1'b1, 32'd100);
        // reverse run, then index low while going backwards
        push_sample(2'd0, 1'b1, 32'd101);
        push_sample(2'd2, 1'b1, 32'd102);
        push_sample(2'd3, 1'b1, 32'd103);
        push_sample(2'd1, 1'b0, 32'd104);
        // two-step jumps both ways, then the same phase again
        push_sample(2'd2, 1'b1, 32'd105);
        push_sample(2'd1, 1'b1, 32'd106);
        push_sample(2'd1, 1'b1, 32'd107);
        // timestamp extremes and wrap-around
        push_sample(2'd3, 1'b1, 32'hFFFF_FFFF);
        push_sample(2'd3, 1'b1, 32'd0);
        push_sample(2'd0, 1'b1, 32'h8000_0000);
        // time going backwards closes the window
        push_sample(2'd2, 1'b1, 32'h7FFF_FFFF);
        // burst of reverse ticks within the same millisecond
        push_sample(2'd3, 1'b1, 32'h7FFF_FFFF);
        push_sample(2'd1, 1'b1, 32'h7FFF_FFFF);
        push_sample(2'd0, 1'b1, 32'h7FFF_FFFF);
        push_sample(2'd2, 1'b1, 32'h7FFF_FFFF);
        push_sample(2'd3, 1'b1, 32'h7FFF_FFFF);
        push_sample(2'd1, 1'b1, 32'h7FFF_FFFF);
        push_sample(2'd0, 1'b1, 32'h8000_0063);

        // random motion at the reset window
        queue_motion(120, 30, 30, -1);

        // shortest window: every sample whose timestamp moves closes it; receiver holds off a long
        // stretch while the sender keeps offering, so the block backs up
        write_window(16'd1);
        queue_motion(150, 3, 50, 90);
        @(negedge clk);
        hold_request = LONG_HOLD;

        // longest window, with big time steps; the sender waits for the block to drain once
        write_window(16'hFFFF);
        max_gap_in = 0;
        queue_motion(120, 20000, 20, 60);

        // zero length behaves as one millisecond; the sender idles again here
        write_window(16'd0);
        max_gap_in = 6;
        queue_motion(100, 2, 60, -1);

        // a mid-range window
        mid_len = 16'($urandom_range(2, 300));
        write_window(mid_len);
        max_stall_out = 0;
        queue_motion(100, 50, 25, 40);

        // short window, neither side idles
        short_len = 16'($urandom_range(2, 40));
        write_window(short_len);
        max_gap_in = 0;
        queue_motion(100, short_len, 40, -1);

        wait_drained();
        $display("%0d samples sent, %0d readings checked, %0d speed windows closed",
                 samples_sent, readings_checked, windows_closed);
        $display("windows 100, 1, 65535, 0, %0d and %0d ms; %0d index hits, %0d phase jumps",
                 mid_len, short_len, index_hits, jumps_seen);
        if (err_count == 0 && readings_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog on the cycle counter
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d readings outstanding",
                 cycle_count, readings_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
